// ----- hw/rtl/pidc_pkg.sv -----
package pidc_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned LIMIT_W   = 31;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned OPND_W    = DATA_W + 1;
  localparam int unsigned PROD_W    = 2 * OPND_W;

  localparam logic signed [DATA_W-1:0] MAX32 = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] MIN32 = 32'sh8000_0000;

  localparam logic [LIMIT_W-1:0] TIME_STEP_RST  = 31'd65536;
  localparam logic [LIMIT_W-1:0] RECIP_RST      = 31'd65536;
  localparam logic [LIMIT_W-1:0] INT_LIMIT_RST  = 31'd327680000;
  localparam logic [LIMIT_W-1:0] OUT_LIMIT_RST  = 31'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT   = 4'd0,
    REG_GAIN_P     = 4'd1,
    REG_GAIN_I     = 4'd2,
    REG_GAIN_D     = 4'd3,
    REG_TIME_STEP  = 4'd4,
    REG_RECIP      = 4'd5,
    REG_INT_LIMIT  = 4'd6,
    REG_OUT_LIMIT  = 4'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_R,
    ST_MUL_T,
    ST_MUL_D,
    ST_CLAMP_I,
    ST_MUL_I,
    ST_SUM,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] gain_p;
    logic signed [DATA_W-1:0] gain_i;
    logic signed [DATA_W-1:0] gain_d;
    logic [LIMIT_W-1:0]       time_step;
    logic [LIMIT_W-1:0]       time_step_recip;
    logic [LIMIT_W-1:0]       integral_limit;
    logic [LIMIT_W-1:0]       drive_limit;
  } cfg_t;

  typedef struct packed {
    logic                     func;
    logic signed [DATA_W-1:0] measured;
    logic signed [DATA_W-1:0] given_error;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic signed [DATA_W-1:0] error_used;
    logic                     integral_clamped;
    logic                     output_clamped;
  } out_t;

endpackage

// ----- hw/rtl/pidc_cfg_regs.sv -----
module pidc_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pidc_pkg::DATA_W-1:0]         cfg_data_i,
  output pidc_pkg::cfg_t                      cfg_o
);

  pidc_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint        <= '0;
      cfg_q.gain_p          <= '0;
      cfg_q.gain_i          <= '0;
      cfg_q.gain_d          <= '0;
      cfg_q.time_step       <= pidc_pkg::TIME_STEP_RST;
      cfg_q.time_step_recip <= pidc_pkg::RECIP_RST;
      cfg_q.integral_limit  <= pidc_pkg::INT_LIMIT_RST;
      cfg_q.drive_limit     <= pidc_pkg::OUT_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (pidc_pkg::cfg_idx_e'(cfg_index_i))
        pidc_pkg::REG_SETPOINT:  cfg_q.setpoint        <= cfg_data_i;
        pidc_pkg::REG_GAIN_P:    cfg_q.gain_p          <= cfg_data_i;
        pidc_pkg::REG_GAIN_I:    cfg_q.gain_i          <= cfg_data_i;
        pidc_pkg::REG_GAIN_D:    cfg_q.gain_d          <= cfg_data_i;
        pidc_pkg::REG_TIME_STEP: cfg_q.time_step       <= cfg_data_i[pidc_pkg::LIMIT_W-1:0];
        pidc_pkg::REG_RECIP:     cfg_q.time_step_recip <= cfg_data_i[pidc_pkg::LIMIT_W-1:0];
        pidc_pkg::REG_INT_LIMIT: cfg_q.integral_limit  <= cfg_data_i[pidc_pkg::LIMIT_W-1:0];
        pidc_pkg::REG_OUT_LIMIT: cfg_q.drive_limit     <= cfg_data_i[pidc_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/pidc_mul.sv -----
module pidc_mul #(
  parameter int unsigned FracBits = pidc_pkg::FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic signed [pidc_pkg::OPND_W-1:0]  a_i,
  input  logic signed [pidc_pkg::OPND_W-1:0]  b_i,
  output logic signed [pidc_pkg::DATA_W-1:0]  sat32_o,
  output logic signed [pidc_pkg::DATA_W+1:0]  sat34_o
);

  localparam int unsigned PW = pidc_pkg::PROD_W;

  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] shifted;

  // product registered, consumed by the sequencer in the next cycle
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  // arithmetic shift gives floor rounding
  assign shifted = prod_q >>> FracBits;

  always_comb begin
    if (&shifted[PW-1:31] || ~|shifted[PW-1:31]) begin
      sat32_o = shifted[31:0];
    end else if (shifted[PW-1]) begin
      sat32_o = pidc_pkg::MIN32;
    end else begin
      sat32_o = pidc_pkg::MAX32;
    end
  end

  // 34-bit clamp keeps the integral increment exact enough for the later sat32
  always_comb begin
    if (&shifted[PW-1:33] || ~|shifted[PW-1:33]) begin
      sat34_o = shifted[33:0];
    end else if (shifted[PW-1]) begin
      sat34_o = {1'b1, 33'd0};
    end else begin
      sat34_o = {1'b0, {33{1'b1}}};
    end
  end

endmodule

// ----- hw/rtl/pid_controller_clamped.sv -----
// one word is worked on at a time, on the single shared 33x33 multiplier
//   that the sequencer uses five times per word
// input stall stays high while a word is in work; a finished word may wait
//   in the output register while the next one is taken
// reset clears integral, previous error, sequencer state and loads register defaults
module pid_controller_clamped #(
  parameter int unsigned FracBits = pidc_pkg::FRAC_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pidc_pkg::DATA_W-1:0]        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  pidc_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output pidc_pkg::out_t                     out_data_o
);

  pidc_pkg::cfg_t   cfg;
  pidc_pkg::state_e state_q, state_d;

  logic signed [31:0] err_q, prev_q, integ_q;
  logic signed [31:0] pterm_q, rate_q, dterm_q;
  logic signed [32:0] diff_q;
  logic signed [33:0] sum_q;
  logic               iclamp_q;
  logic               out_valid_q;
  pidc_pkg::out_t     out_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [31:0] mul_sat32;
  logic signed [33:0] mul_sat34;

  logic signed [32:0] err_raw;
  logic signed [31:0] err_new;
  logic signed [34:0] integ_sum;
  logic signed [31:0] integ_sat;
  logic signed [32:0] ilim, ilim_n;
  logic signed [33:0] olim, olim_n;
  logic signed [33:0] sum_c;
  logic signed [31:0] drive_c;
  logic               oclamp_c;
  logic               accept;
  logic               out_free;

  pidc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pidc_mul #(
    .FracBits (FracBits)
  ) u_mul (
    .clk_i   (clk_i),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .sat32_o (mul_sat32),
    .sat34_o (mul_sat34)
  );

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // error select with saturating subtract
  always_comb begin
    err_raw = {cfg.setpoint[31], cfg.setpoint} - {in_data_i.measured[31], in_data_i.measured};
    if (in_data_i.func) begin
      err_new = in_data_i.given_error;
    end else if (err_raw[32] != err_raw[31]) begin
      err_new = err_raw[32] ? pidc_pkg::MIN32 : pidc_pkg::MAX32;
    end else begin
      err_new = err_raw[31:0];
    end
  end

  // integral accumulate, saturated to 32 bits
  always_comb begin
    integ_sum = {{3{integ_q[31]}}, integ_q} + {mul_sat34[33], mul_sat34};
    if (&integ_sum[34:31] || ~|integ_sum[34:31]) begin
      integ_sat = integ_sum[31:0];
    end else begin
      integ_sat = integ_sum[34] ? pidc_pkg::MIN32 : pidc_pkg::MAX32;
    end
  end

  assign ilim   = {2'b00, cfg.integral_limit};
  assign ilim_n = -ilim;
  assign olim   = {3'b000, cfg.drive_limit};
  assign olim_n = -olim;

  // output clamp then 32-bit saturation
  always_comb begin
    oclamp_c = 1'b0;
    sum_c    = sum_q;
    if (cfg.drive_limit != '0) begin
      if (sum_q > olim) begin
        sum_c    = olim;
        oclamp_c = 1'b1;
      end else if (sum_q < olim_n) begin
        sum_c    = olim_n;
        oclamp_c = 1'b1;
      end
    end
    if (&sum_c[33:31] || ~|sum_c[33:31]) begin
      drive_c = sum_c[31:0];
    end else begin
      drive_c = sum_c[33] ? pidc_pkg::MIN32 : pidc_pkg::MAX32;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pidc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_q)
      pidc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = pidc_pkg::ST_MUL_P;
        end
      end
      pidc_pkg::ST_MUL_P: begin
        mul_a   = {cfg.gain_p[31], cfg.gain_p};
        mul_b   = {err_q[31], err_q};
        state_d = pidc_pkg::ST_MUL_R;
      end
      pidc_pkg::ST_MUL_R: begin
        mul_a   = diff_q;
        mul_b   = {2'b00, cfg.time_step_recip};
        state_d = pidc_pkg::ST_MUL_T;
      end
      pidc_pkg::ST_MUL_T: begin
        mul_a   = {err_q[31], err_q};
        mul_b   = {2'b00, cfg.time_step};
        state_d = pidc_pkg::ST_MUL_D;
      end
      pidc_pkg::ST_MUL_D: begin
        mul_a   = {cfg.gain_d[31], cfg.gain_d};
        mul_b   = {rate_q[31], rate_q};
        state_d = pidc_pkg::ST_CLAMP_I;
      end
      pidc_pkg::ST_CLAMP_I: begin
        state_d = pidc_pkg::ST_MUL_I;
      end
      pidc_pkg::ST_MUL_I: begin
        mul_a   = {cfg.gain_i[31], cfg.gain_i};
        mul_b   = {integ_q[31], integ_q};
        state_d = pidc_pkg::ST_SUM;
      end
      pidc_pkg::ST_SUM: begin
        state_d = pidc_pkg::ST_OUT;
      end
      pidc_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = pidc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pidc_pkg::ST_IDLE;
      end
    endcase
  end

  // loop state and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      integ_q     <= '0;
      iclamp_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == pidc_pkg::ST_MUL_P) begin
        prev_q <= err_q;
      end
      if (state_q == pidc_pkg::ST_MUL_D) begin
        integ_q <= integ_sat;
      end
      if (state_q == pidc_pkg::ST_CLAMP_I) begin
        if (cfg.integral_limit != '0 && $signed({integ_q[31], integ_q}) > ilim) begin
          integ_q  <= ilim[31:0];
          iclamp_q <= 1'b1;
        end else if (cfg.integral_limit != '0 &&
                     $signed({integ_q[31], integ_q}) < ilim_n) begin
          integ_q  <= ilim_n[31:0];
          iclamp_q <= 1'b1;
        end else begin
          iclamp_q <= 1'b0;
        end
      end
      if (state_q == pidc_pkg::ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      err_q <= err_new;
    end
    if (state_q == pidc_pkg::ST_MUL_P) begin
      diff_q <= {err_q[31], err_q} - {prev_q[31], prev_q};
    end
    if (state_q == pidc_pkg::ST_MUL_R) begin
      pterm_q <= mul_sat32;
    end
    if (state_q == pidc_pkg::ST_MUL_T) begin
      rate_q <= mul_sat32;
    end
    if (state_q == pidc_pkg::ST_CLAMP_I) begin
      dterm_q <= mul_sat32;
    end
    if (state_q == pidc_pkg::ST_SUM) begin
      sum_q <= {{2{pterm_q[31]}}, pterm_q} + {{2{mul_sat32[31]}}, mul_sat32}
             + {{2{dterm_q[31]}}, dterm_q};
    end
    if (state_q == pidc_pkg::ST_OUT && out_free) begin
      out_q.drive            <= drive_c;
      out_q.error_used       <= err_q;
      out_q.integral_clamped <= iclamp_q;
      out_q.output_clamped   <= oclamp_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == pidc_pkg::ST_MUL_P)
    else $error("accepted word did not start the sequence");

  a_integ_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pidc_pkg::ST_MUL_I && cfg.integral_limit != '0)
    |-> ($signed({integ_q[31], integ_q}) <= ilim &&
         $signed({integ_q[31], integ_q}) >= ilim_n))
    else $error("integral outside its limit after clamp");

  a_oclamp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.output_clamped)
    |-> (out_data_o.drive == olim[31:0] || out_data_o.drive == olim_n[31:0]))
    else $error("clamped drive not at the output limit");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pidc_pkg::ST_OUT && !out_free) |=> state_q == pidc_pkg::ST_OUT)
    else $error("sequencer left while output register was full");
`endif

endmodule
